[rtl/core/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion unit.
// Depends on nothing; every other file in rtl/core uses it.
package rmq_pkg;

  // Fixed point format of every matrix entry and quaternion component.
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;

  // An off-diagonal sum or difference, and its magnitude.
  localparam int NUM_W = IN_W + 1;
  localparam int MAG_W = IN_W + 1;

  // Candidate sums hold one plus three entries.
  localparam int CAND_W = ((FRAC_BITS > IN_W) ? FRAC_BITS : IN_W) + 3;
  localparam int BEST_W = CAND_W - 1;

  // Square root input is the winning candidate shifted left by FRAC_BITS-2.
  localparam int RAD_W  = BEST_W + FRAC_BITS - 2;
  localparam int ROOT_W = (RAD_W + 1) / 2;
  localparam int SREM_W = ROOT_W + 2;
  localparam int DEN_W  = ROOT_W + 2;

  // The quotient never exceeds 2^15 + 1, since the root is at least one half.
  localparam int QUO_W = 17;
  localparam int DVD_W = MAG_W + FRAC_BITS + 1;
  localparam int SAT_W = (ROOT_W > QUO_W) ? ROOT_W : QUO_W;

  // Back end stages: one per root bit, one to form dividends, one per quotient bit.
  localparam int SQ_ST = ROOT_W;
  localparam int N_ST  = SQ_ST + 1 + QUO_W;

  // Queue between front and back.
  localparam int FQ_DEPTH = 2;
  localparam int FQ_AW    = 1;

  // Branch codes.
  localparam logic [1:0] BR_X = 2'd0;
  localparam logic [1:0] BR_Y = 2'd1;
  localparam logic [1:0] BR_Z = 2'd2;
  localparam logic [1:0] BR_W = 2'd3;

  typedef struct packed {
    logic signed [IN_W-1:0] r11;
    logic signed [IN_W-1:0] r12;
    logic signed [IN_W-1:0] r13;
    logic signed [IN_W-1:0] r21;
    logic signed [IN_W-1:0] r22;
    logic signed [IN_W-1:0] r23;
    logic signed [IN_W-1:0] r31;
    logic signed [IN_W-1:0] r32;
    logic signed [IN_W-1:0] r33;
  } in_word_t;

  typedef struct packed {
    logic signed [IN_W-1:0] qx;
    logic signed [IN_W-1:0] qy;
    logic signed [IN_W-1:0] qz;
    logic signed [IN_W-1:0] qw;
    logic [1:0]             branch;
  } out_word_t;

  // Classified item: chosen branch, winning candidate, and the three
  // numerators of the other components in increasing slot order.
  typedef struct packed {
    logic [1:0]                 sel;
    logic [BEST_W-1:0]          best;
    logic [2:0]                 neg;
    logic [2:0][MAG_W-1:0]      mag;
  } fr_word_t;

endpackage

[rtl/core/rmq_front.sv]
// Front end: picks the largest candidate and the numerators of each matrix and registers them.
// Depends on rmq_pkg.
module rmq_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rmq_pkg::in_word_t in_word_i,
  output logic              fr_valid_o,
  input  logic              fr_ready_i,
  output rmq_pkg::fr_word_t fr_word_o
);

  localparam int CW = rmq_pkg::CAND_W;
  localparam int NW = rmq_pkg::NUM_W;

  logic                     vld_q, vld_d;
  rmq_pkg::fr_word_t        word_q, word_d;
  logic signed [CW-1:0]     one, e11, e22, e33;
  logic signed [CW-1:0]     cand0, cand1, cand2, cand3, best;
  logic [1:0]               sel;
  logic signed [NW-1:0]     sxy, sxz, syz, dzy, dxz, dyx;
  logic signed [2:0][NW-1:0] num;

  assign in_stall_o = vld_q && !fr_ready_i;

  // Candidate sums from the diagonal.
  always_comb begin
    one   = CW'(1) <<< rmq_pkg::FRAC_BITS;
    e11   = CW'(in_word_i.r11);
    e22   = CW'(in_word_i.r22);
    e33   = CW'(in_word_i.r33);
    cand0 = one + e11 - e22 - e33;
    cand1 = one - e11 + e22 - e33;
    cand2 = one - e11 - e22 + e33;
    cand3 = one + e11 + e22 + e33;
  end

  // Largest candidate; a later one wins a tie.
  always_comb begin
    best = cand0;
    sel  = rmq_pkg::BR_X;
    if (cand1 >= best) begin
      best = cand1;
      sel  = rmq_pkg::BR_Y;
    end
    if (cand2 >= best) begin
      best = cand2;
      sel  = rmq_pkg::BR_Z;
    end
    if (cand3 >= best) begin
      best = cand3;
      sel  = rmq_pkg::BR_W;
    end
  end

  // Off-diagonal sums and differences, ordered by the slots that use them.
  always_comb begin
    sxy = NW'(in_word_i.r21) + NW'(in_word_i.r12);
    sxz = NW'(in_word_i.r31) + NW'(in_word_i.r13);
    syz = NW'(in_word_i.r32) + NW'(in_word_i.r23);
    dzy = NW'(in_word_i.r32) - NW'(in_word_i.r23);
    dxz = NW'(in_word_i.r13) - NW'(in_word_i.r31);
    dyx = NW'(in_word_i.r21) - NW'(in_word_i.r12);
    unique case (sel)
      rmq_pkg::BR_X: num = {dzy, sxz, sxy};
      rmq_pkg::BR_Y: num = {dxz, syz, sxy};
      rmq_pkg::BR_Z: num = {dyx, syz, sxz};
      rmq_pkg::BR_W: num = {dyx, dxz, dzy};
      default:       num = {dyx, dxz, dzy};
    endcase
  end

  // Build the classified word.
  always_comb begin
    word_d.sel  = sel;
    word_d.best = best[rmq_pkg::BEST_W-1:0];
    for (int j = 0; j < 3; j++) begin
      word_d.neg[j] = num[j][NW-1];
      word_d.mag[j] = rmq_pkg::MAG_W'(num[j][NW-1] ? -num[j] : num[j]);
    end
  end

  assign vld_d = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      word_q <= word_d;
    end
  end

  assign fr_valid_o = vld_q;
  assign fr_word_o  = word_q;

endmodule

[rtl/core/rmq_fifo.sv]
// Two-word queue that decouples the front end from the back end.
// Depends on rmq_pkg.
module rmq_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  rmq_pkg::fr_word_t word_i,
  output logic              nempty_o,
  input  logic              pop_i,
  output rmq_pkg::fr_word_t word_o
);

  rmq_pkg::fr_word_t                  mem_q [rmq_pkg::FQ_DEPTH];
  logic [rmq_pkg::FQ_AW-1:0]          wptr_q, rptr_q;
  logic [rmq_pkg::FQ_AW:0]            cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign ready_o  = (cnt_q != (rmq_pkg::FQ_AW + 1)'(rmq_pkg::FQ_DEPTH));
  assign nempty_o = (cnt_q != '0);
  assign do_push  = push_i && ready_o;
  assign do_pop   = pop_i && nempty_o;
  assign word_o   = mem_q[rptr_q];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= word_i;
    end
  end

endmodule

[rtl/core/rmq_back.sv]
// Back end: pipelined square root, then three pipelined dividers and saturation.
// Depends on rmq_pkg.
module rmq_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fq_nempty_i,
  output logic               fq_pop_o,
  input  rmq_pkg::fr_word_t  fq_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rmq_pkg::out_word_t out_word_o
);

  localparam int RW  = rmq_pkg::ROOT_W;
  localparam int SW  = rmq_pkg::SREM_W;
  localparam int DW  = rmq_pkg::DEN_W;
  localparam int QW  = rmq_pkg::QUO_W;
  localparam int VW  = rmq_pkg::DVD_W;
  localparam int TW  = rmq_pkg::SAT_W;
  localparam int NS  = rmq_pkg::N_ST;

  typedef struct packed {
    logic [1:0]                   sel;
    logic [2:0]                   neg;
    logic [2:0][rmq_pkg::MAG_W-1:0] mag;
    logic [2*RW-1:0]              rad;
    logic [SW-1:0]                srem;
    logic [RW-1:0]                root;
    logic [2:0][QW-1:0]           dlo;
    logic [2:0][DW-1:0]           drem;
  } bk_pipe_t;

  bk_pipe_t              pipe_q [NS+1];
  logic [NS:0]           vld_q;
  logic                  en;
  bk_pipe_t              head;
  rmq_pkg::out_word_t    out_q, res;
  logic                  out_vld_q;

  // One stage: a root bit, the dividend setup, or a quotient bit.
  function automatic bk_pipe_t bk_step(input bk_pipe_t s, input int k);
    bk_pipe_t         n;
    logic [SW+1:0]    rr, trial;
    logic [VW-1:0]    dvd;
    logic [DW:0]      dr, den;
    n = s;
    if (k < rmq_pkg::SQ_ST) begin
      rr    = {s.srem, s.rad[2*RW-1 -: 2]};
      trial = (SW + 2)'({s.root, 2'b01});
      n.rad = {s.rad[2*RW-3:0], 2'b00};
      if (rr >= trial) begin
        n.srem = SW'(rr - trial);
        n.root = {s.root[RW-2:0], 1'b1};
      end else begin
        n.srem = SW'(rr);
        n.root = {s.root[RW-2:0], 1'b0};
      end
    end else if (k == rmq_pkg::SQ_ST) begin
      for (int j = 0; j < 3; j++) begin
        dvd       = (VW'(s.mag[j]) << rmq_pkg::FRAC_BITS) + (VW'(s.root) << 1);
        n.drem[j] = DW'(dvd >> QW);
        n.dlo[j]  = dvd[QW-1:0];
      end
    end else begin
      den = (DW + 1)'({s.root, 2'b00});
      for (int j = 0; j < 3; j++) begin
        dr = {s.drem[j], s.dlo[j][QW-1]};
        if (dr >= den) begin
          n.drem[j] = DW'(dr - den);
          n.dlo[j]  = {s.dlo[j][QW-2:0], 1'b1};
        end else begin
          n.drem[j] = DW'(dr);
          n.dlo[j]  = {s.dlo[j][QW-2:0], 1'b0};
        end
      end
    end
    return n;
  endfunction

  // Sign and clamp a magnitude to the 16-bit output range.
  function automatic logic signed [rmq_pkg::IN_W-1:0] sat_q(input logic neg,
                                                            input logic [TW-1:0] m);
    logic signed [rmq_pkg::IN_W-1:0] r;
    if (neg) begin
      if (m >= TW'(32768)) begin
        r = 16'sh8000;
      end else begin
        r = 16'sd0 - $signed(m[15:0]);
      end
    end else begin
      if (m > TW'(32767)) begin
        r = 16'sh7fff;
      end else begin
        r = $signed(m[15:0]);
      end
    end
    return r;
  endfunction

  // The whole pipeline moves unless a finished word is stuck at the output.
  assign en       = !out_vld_q || !out_stall_i;
  assign fq_pop_o = en && fq_nempty_i;

  // First stage word straight from the queue.
  always_comb begin
    head      = '0;
    head.sel  = fq_word_i.sel;
    head.neg  = fq_word_i.neg;
    head.mag  = fq_word_i.mag;
    head.rad  = (2 * RW)'(fq_word_i.best) << (rmq_pkg::FRAC_BITS - 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NS-1:0], fq_nempty_i};
      out_vld_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pipe_q[0] <= head;
      for (int k = 0; k < NS; k++) begin
        pipe_q[k+1] <= bk_step(pipe_q[k], k);
      end
      out_q <= res;
    end
  end

  // Place the root and the three quotients into their slots.
  // Slots below the chosen one use their own numerator, slots above it the one before.
  always_comb begin
    logic signed [3:0][rmq_pkg::IN_W-1:0] q;
    logic [1:0] ix;
    bk_pipe_t f;
    f = pipe_q[NS];
    for (int t = 0; t < 4; t++) begin
      ix = (2'(t) < f.sel) ? 2'(t) : 2'(t) - 2'd1;
      if (2'(t) == f.sel) begin
        q[t] = sat_q(1'b0, TW'(f.root));
      end else begin
        q[t] = sat_q(f.neg[ix], TW'(f.dlo[ix]));
      end
    end
    res.qx     = q[0];
    res.qy     = q[1];
    res.qz     = q[2];
    res.qw     = q[3];
    res.branch = f.sel;
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

endmodule

[rtl/core/rotation_matrix_to_quaternion_unit.sv]
// Top level of the rotation matrix to quaternion unit.
// Depends on rmq_pkg, rmq_front, rmq_fifo and rmq_back.
//
//   channel | signals                               | word
//   input   | in_valid_i, in_stall_o, in_word_i     | nine Q1.14 matrix entries
//   output  | out_valid_o, out_stall_i, out_word_o  | qx qy qz qw and branch
//
// One word is taken every cycle while in_stall_o is low; each word passes through the
// front register, queue write, queue read stage, 15 square root stages,
// one dividend stage, 17 divider stages and the output register.
// Reset clears only the valid bits and the queue pointers and count.
// A stall on a valid output word freezes the back end; the two-word queue lets the
// front end keep taking words until it fills.
module rotation_matrix_to_quaternion_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rmq_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rmq_pkg::out_word_t out_word_o
);

  logic              fr_valid, fq_ready, fq_nempty, fq_pop;
  rmq_pkg::fr_word_t fr_word, fq_word;

  rmq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .fr_valid_o (fr_valid),
    .fr_ready_i (fq_ready),
    .fr_word_o  (fr_word)
  );

  rmq_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (fr_valid),
    .ready_o  (fq_ready),
    .word_i   (fr_word),
    .nempty_o (fq_nempty),
    .pop_i    (fq_pop),
    .word_o   (fq_word)
  );

  rmq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fq_nempty_i (fq_nempty),
    .fq_pop_o    (fq_pop),
    .fq_word_i   (fq_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[sim/rotation_matrix_to_quaternion_unit_test.sv]
// Testbench for the rotation matrix to quaternion unit: directed and random matrices.
// Depends on rmq_pkg and rotation_matrix_to_quaternion_unit; predicts each word in place.
module rotation_matrix_to_quaternion_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  rmq_pkg::in_word_t in_word_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rmq_pkg::out_word_t out_word_o;

  rmq_pkg::out_word_t quat_queue[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  localparam int CYCLE_LIMIT = 400000;

  rotation_matrix_to_quaternion_unit u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_word_i,
    .out_valid_o, .out_stall_i, .out_word_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Integer square root rounded down.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned lo, hi, mid;
    lo = 0;
    hi = 64'd4294967295;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // Scaled quotient rounded to nearest with ties away from zero.
  function automatic longint scaled_quot(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag <<< rmq_pkg::FRAC_BITS) + (den >>> 1)) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic rmq_pkg::out_word_t predict_quat(rmq_pkg::in_word_t m);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33;
    longint cand[4];
    longint q[4];
    longint best, root, den;
    logic [1:0] sel;
    rmq_pkg::out_word_t r;
    a11 = m.r11; a12 = m.r12; a13 = m.r13;
    a21 = m.r21; a22 = m.r22; a23 = m.r23;
    a31 = m.r31; a32 = m.r32; a33 = m.r33;
    cand[0] = (1 <<< rmq_pkg::FRAC_BITS) + a11 - a22 - a33;
    cand[1] = (1 <<< rmq_pkg::FRAC_BITS) - a11 + a22 - a33;
    cand[2] = (1 <<< rmq_pkg::FRAC_BITS) - a11 - a22 + a33;
    cand[3] = (1 <<< rmq_pkg::FRAC_BITS) + a11 + a22 + a33;
    best = cand[0];
    sel = rmq_pkg::BR_X;
    for (int k = 1; k < 4; k++) begin
      if (cand[k] >= best) begin
        best = cand[k];
        sel = k[1:0];
      end
    end
    root = longint'(floor_root(longint'(best) <<< (rmq_pkg::FRAC_BITS - 2)));
    den = root <<< 2;
    case (sel)
      rmq_pkg::BR_X: begin
        q[0] = root; q[1] = scaled_quot(a21 + a12, den);
        q[2] = scaled_quot(a31 + a13, den); q[3] = scaled_quot(a32 - a23, den);
      end
      rmq_pkg::BR_Y: begin
        q[0] = scaled_quot(a21 + a12, den); q[1] = root;
        q[2] = scaled_quot(a32 + a23, den); q[3] = scaled_quot(a13 - a31, den);
      end
      rmq_pkg::BR_Z: begin
        q[0] = scaled_quot(a31 + a13, den); q[1] = scaled_quot(a32 + a23, den);
        q[2] = root; q[3] = scaled_quot(a21 - a12, den);
      end
      default: begin
        q[0] = scaled_quot(a32 - a23, den); q[1] = scaled_quot(a13 - a31, den);
        q[2] = scaled_quot(a21 - a12, den); q[3] = root;
      end
    endcase
    r.qx = clamp16(q[0]);
    r.qy = clamp16(q[1]);
    r.qz = clamp16(q[2]);
    r.qw = clamp16(q[3]);
    r.branch = sel;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on word %0d: %s got %0d expected %0d", words_checked, what, got, want);
    errors++;
  endtask

  // Drive one word and hold it until the unit takes it.
  // Valid stays high afterwards; an idle cycle or the drain wait drops it.
  task automatic send_matrix(rmq_pkg::in_word_t m);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= m;
    quat_queue.insert(quat_queue.size(), predict_quat(m));
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Random stall on the output side.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 15);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (quat_queue.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        rmq_pkg::out_word_t e;
        e = quat_queue.pop_front();
        if (out_word_o.qx !== e.qx) report_mismatch("qx", out_word_o.qx, e.qx);
        if (out_word_o.qy !== e.qy) report_mismatch("qy", out_word_o.qy, e.qy);
        if (out_word_o.qz !== e.qz) report_mismatch("qz", out_word_o.qz, e.qz);
        if (out_word_o.qw !== e.qw) report_mismatch("qw", out_word_o.qw, e.qw);
        if (out_word_o.branch !== e.branch)
          report_mismatch("branch", out_word_o.branch, e.branch);
      end
      words_checked <= words_checked + 1;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("rotation_matrix_to_quaternion_unit test failed");
      $finish;
    end
  end

  function automatic rmq_pkg::in_word_t diag_matrix(int d1, int d2, int d3);
    rmq_pkg::in_word_t m;
    m = '0;
    m.r11 = d1[15:0]; m.r22 = d2[15:0]; m.r33 = d3[15:0];
    return m;
  endfunction

  function automatic rmq_pkg::in_word_t noise_matrix();
    return {$urandom, $urandom, $urandom, $urandom, 16'($urandom)};
  endfunction

  // Near-rotation: diagonal picks a branch, off-diagonals are small and random.
  function automatic rmq_pkg::in_word_t rotation_like();
    rmq_pkg::in_word_t m;
    m = noise_matrix();
    m.r12 = $signed(m.r12) >>> $urandom_range(1, 4);
    m.r13 = $signed(m.r13) >>> $urandom_range(1, 4);
    m.r21 = $signed(m.r21) >>> $urandom_range(1, 4);
    m.r23 = $signed(m.r23) >>> $urandom_range(1, 4);
    m.r31 = $signed(m.r31) >>> $urandom_range(1, 4);
    m.r32 = $signed(m.r32) >>> $urandom_range(1, 4);
    m.r11 = $signed(m.r11) >>> 1;
    m.r22 = $signed(m.r22) >>> 1;
    m.r33 = $signed(m.r33) >>> 1;
    return m;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (quat_queue.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  // Identity, half turns about each axis, ties, and full-scale entries.
  task automatic test_directed();
    rmq_pkg::in_word_t m;
    send_matrix(diag_matrix(16384, 16384, 16384));
    send_matrix(diag_matrix(16384, -16384, -16384));
    send_matrix(diag_matrix(-16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, 16384));
    send_matrix(diag_matrix(0, 0, 0));
    send_matrix(diag_matrix(16384, 16384, -16384));
    send_matrix(diag_matrix(-16384, -16384, -16384));
    send_matrix('0);
    send_matrix('1);
    send_matrix({9{16'sh7fff}});
    send_matrix({9{16'sh8000}});
    send_matrix(diag_matrix(32767, -32768, -32768));
    send_matrix(diag_matrix(-32768, -32768, 32767));
    m = diag_matrix(-32768, -32768, -32768);
    m.r12 = 16'sh7fff; m.r21 = 16'sh7fff; m.r13 = 16'sh8000; m.r31 = 16'sh8000;
    send_matrix(m);
    m = diag_matrix(32767, 32767, 32767);
    m.r32 = 16'sh7fff; m.r23 = 16'sh8000; m.r13 = 16'sh7fff; m.r31 = 16'sh8000;
    m.r21 = 16'sh7fff; m.r12 = 16'sh8000;
    send_matrix(m);
    // A quarter turn about z.
    m = diag_matrix(0, 0, 16384);
    m.r12 = -16'sd16384; m.r21 = 16'sd16384;
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) send_matrix(rotation_like());
      else send_matrix(noise_matrix());
    end
  endtask

  // Back-to-back words with neither side idling.
  task automatic test_full_rate(int count);
    calm = 1'b1;
    test_random(count);
    calm = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    wait_drained();
    test_full_rate(120);
    test_random(230);
    wait_drained();
    $display("sent %0d matrices (directed extremes, near-rotations, noise)", words_sent);
    $display("checked %0d quaternion words under random and no stall", words_checked);
    if (errors == 0) begin
      $display("rotation_matrix_to_quaternion_unit test passed");
    end else begin
      $display("rotation_matrix_to_quaternion_unit test failed");
    end
    $finish;
  end
endmodule
